// ===== src/base64_stream_decoder_assert.svh =====
// Assertion macros for the base64 stream decoder.
// Depends on nothing; included by the top level only.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define B64D_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/b64d_pkg.sv =====
// Shared types, constants and the character map of the base64 stream decoder.
// No dependencies.
package b64d_pkg;

   // Character classes decided by the front end
   localparam logic [1:0] KIND_SKIP = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_PAD  = 2'd2;
   localparam logic [1:0] KIND_ZERO = 2'd3;

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [7:0] ZERO_CHAR = 8'h00;

   // Queue between front end and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] sextet;
      logic       last;
   } b64d_item_type;

   typedef struct packed {
      logic [1:0] phase;
      logic       stopped;
      logic       pad_error;
   } b64d_status_type;

   // Map a character to its class and 6-bit value
   function automatic b64d_item_type classify(input logic [7:0] c, input logic last);
      b64d_item_type item;
      item.kind   = KIND_SKIP;
      item.sextet = 6'd0;
      item.last   = last;
      if (c == ZERO_CHAR) begin
         item.kind = KIND_ZERO;
      end else if (c == PAD_CHAR) begin
         item.kind = KIND_PAD;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'd62;
      end else if (c == 8'h2F) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'd63;
      end
      return item;
   endfunction

endpackage

// ===== src/b64d_front.sv =====
// Front end: accepts characters, classifies them and drops plain skips.
// Depends on b64d_pkg.
module b64d_front
   import b64d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_in_char,
   input  logic          req_last,
   output logic          push_valid,
   input  logic          push_ready,
   output b64d_item_type push_item
);

   logic          valid_ff, valid_in;
   b64d_item_type item_ff, item_in;
   logic          req_accept;
   logic          push_done;
   b64d_item_type class_item;

   // Classify the incoming character
   assign class_item = classify(req_in_char, req_last);

   // Stall while the stage holds an item that the queue cannot take
   assign req_stall  = valid_ff && !push_ready;
   assign req_accept = req_valid && !req_stall;
   assign push_done  = valid_ff && push_ready;

   // Keep anything the back end must see; drop plain skips
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_accept) begin
         valid_in = (class_item.kind != KIND_SKIP) || class_item.last;
         item_in  = class_item;
      end else if (push_done) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// ===== src/b64d_queue.sv =====
// Short FIFO of classified transactions between front end and back end.
// Depends on b64d_pkg.
module b64d_queue
   import b64d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  b64d_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output b64d_item_type pop_item
);

   b64d_item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]        count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = count_ff != QUEUE_CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QUEUE_CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/b64d_back.sv =====
// Back end: packs sextets into bytes, tracks pad and stop state, and
// registers results. Depends on b64d_pkg.
module b64d_back
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  b64d_item_type   pop_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_has_byte,
   output logic            rsp_end_of_stream,
   output logic            rsp_bad_padding,
   output b64d_status_type status
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] partial_ff, partial_in;
   logic       pad_error_ff, pad_error_in;
   logic       stopped_ff, stopped_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_has_ff, out_has_in;
   logic       out_end_ff, out_end_in;
   logic       out_bad_ff, out_bad_in;
   logic       do_pop;
   logic       got;
   logic [7:0] byte_val;
   logic       emit;

   // Take a transaction whenever the output register is free or draining
   assign pop_ready = !out_valid_ff || !rsp_stall;
   assign do_pop    = pop_valid && pop_ready;

   // Decode one transaction against the current state
   always_comb begin
      phase_in     = phase_ff;
      partial_in   = partial_ff;
      pad_error_in = pad_error_ff;
      stopped_in   = stopped_ff;
      got          = 1'b0;
      byte_val     = 8'd0;
      if (!stopped_ff) begin
         case (pop_item.kind)
            KIND_ZERO: begin
               stopped_in = 1'b1;
            end
            KIND_PAD: begin
               if (phase_ff == 2'd1) begin
                  pad_error_in = 1'b1;
               end
            end
            KIND_DATA: begin
               case (phase_ff)
                  2'd0: begin
                     partial_in = {pop_item.sextet, 2'b00};
                  end
                  2'd1: begin
                     got        = 1'b1;
                     byte_val   = partial_ff | {6'd0, pop_item.sextet[5:4]};
                     partial_in = {pop_item.sextet[3:0], 4'd0};
                  end
                  2'd2: begin
                     got        = 1'b1;
                     byte_val   = partial_ff | {4'd0, pop_item.sextet[5:2]};
                     partial_in = {pop_item.sextet[1:0], 6'd0};
                  end
                  default: begin
                     got        = 1'b1;
                     byte_val   = partial_ff | {2'd0, pop_item.sextet};
                     partial_in = 8'd0;
                  end
               endcase
               phase_in = 2'(phase_ff + 1'b1);
            end
            default: begin
            end
         endcase
      end
      emit = got || pop_item.last;
   end

   // Build the next result register contents
   always_comb begin
      out_valid_in = rsp_stall ? out_valid_ff : 1'b0;
      out_byte_in  = out_byte_ff;
      out_has_in   = out_has_ff;
      out_end_in   = out_end_ff;
      out_bad_in   = out_bad_ff;
      if (do_pop && emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_val;
         out_has_in   = got;
         out_end_in   = pop_item.last;
         out_bad_in   = pop_item.last && pad_error_in;
      end
   end

   // Hold decoder state; clear it at the end of each stream
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 2'd0;
         partial_ff   <= 8'd0;
         pad_error_ff <= 1'b0;
         stopped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (do_pop) begin
            if (pop_item.last) begin
               phase_ff     <= 2'd0;
               partial_ff   <= 8'd0;
               pad_error_ff <= 1'b0;
               stopped_ff   <= 1'b0;
            end else begin
               phase_ff     <= phase_in;
               partial_ff   <= partial_in;
               pad_error_ff <= pad_error_in;
               stopped_ff   <= stopped_in;
            end
         end
      end
      out_byte_ff <= out_byte_in;
      out_has_ff  <= out_has_in;
      out_end_ff  <= out_end_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_has_byte      = out_has_ff;
   assign rsp_end_of_stream = out_end_ff;
   assign rsp_bad_padding   = out_bad_ff;

   assign status.phase     = phase_ff;
   assign status.stopped   = stopped_ff;
   assign status.pad_error = pad_error_ff;

endmodule

// ===== src/base64_stream_decoder.sv =====
// Streaming base64 decoder. It takes one character per transaction and
// sustains one character per clock cycle when the result side does not
// stall; that rate is set by the decode step in the back end, which
// updates phase and partial byte for each character. A character passes
// through the front register and the queue before it reaches the result
// register. Characters outside the base64 alphabet give no result unless
// marked last: plain skips are dropped in the front end, while pad and zero
// characters go on to the back end for their effect on the decoder state.
// A transaction marked last always gives exactly one result with end set.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back and the assertion
// macro header.
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_end_of_stream,
   output logic       rsp_bad_padding
);

   logic            push_valid, push_ready;
   b64d_item_type   push_item;
   logic            pop_valid, pop_ready;
   b64d_item_type   pop_item;
   b64d_status_type status;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .req_last    (req_last),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   b64d_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_item          (pop_item),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_bad_padding   (rsp_bad_padding),
      .status            (status)
   );

   // A result without a byte comes only from the end of a stream
   `B64D_ASSERT_NOW(a_empty_result_is_end, clock, reset, rsp_valid && !rsp_has_byte, rsp_end_of_stream, "result without byte lacks end of stream")

   // A pad error is reported only on the end-of-stream result
   `B64D_ASSERT_NOW(a_bad_pad_only_at_end, clock, reset, rsp_valid && rsp_bad_padding, rsp_end_of_stream, "bad padding flagged before stream end")

   // Decoder state is back at its start after the last transaction is taken
   `B64D_ASSERT_NEXT(a_state_cleared_after_last, clock, reset, pop_valid && pop_ready && pop_item.last, status.phase == 2'd0 && !status.stopped && !status.pad_error, "decoder state not cleared after stream end")

   // Every transaction marked last produces a result right away
   `B64D_ASSERT_NEXT(a_last_gives_result, clock, reset, pop_valid && pop_ready && pop_item.last, rsp_valid && rsp_end_of_stream, "last transaction gave no end result")

endmodule
